FILE: hw/rtl/pgp_pkg.sv
// Shared constants, register codes and angle helpers for the ground-plane projection block.
`default_nettype none

package pgp_pkg;

  localparam int PIXEL_BITS_DEF      = 12;
  localparam int ANGLE_FRAC_BITS_DEF = 13;
  localparam int CORDIC_STAGES_DEF   = 16;
  localparam int CORDIC_MAX_STAGES   = 24;

  localparam int BOX_FW   = 12;
  localparam int SCORE_W  = 16;
  localparam int REG_W    = 16;
  localparam int REG_IDXW = 3;

  localparam logic signed [31:0] TAN_MIN_Q = 32'sd7;
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

  localparam logic [15:0] RST_CENTRE_X     = 16'd32768;
  localparam logic [15:0] RST_CENTRE_Y     = 16'd24576;
  localparam logic [15:0] RST_FOCAL_X      = 16'd9600;
  localparam logic [15:0] RST_FOCAL_Y      = 16'd9600;
  localparam logic [15:0] RST_MOUNT_X      = 16'd0;
  localparam logic [15:0] RST_MOUNT_Y      = 16'd0;
  localparam logic [15:0] RST_MOUNT_HEIGHT = 16'd500;
  localparam logic [15:0] RST_MOUNT_PITCH  = 16'd0;

  typedef enum logic [REG_IDXW-1:0] {
    REG_CENTRE_X     = 3'd0,
    REG_CENTRE_Y     = 3'd1,
    REG_FOCAL_X      = 3'd2,
    REG_FOCAL_Y      = 3'd3,
    REG_MOUNT_X      = 3'd4,
    REG_MOUNT_Y      = 3'd5,
    REG_MOUNT_HEIGHT = 3'd6,
    REG_MOUNT_PITCH  = 3'd7
  } cfg_reg_e;

  localparam logic [31:0] ATAN_Q30 [CORDIC_MAX_STAGES] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
    32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
    32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
    32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255, 32'd127
  };

  // Rounds a Q2.30 angle to the internal angle format.
  function automatic logic [32:0] angle_const(input logic [31:0] q30, input int afb);
    int          s;
    logic [32:0] sum;
    s   = 30 - afb;
    sum = {1'b0, q30} + (33'd1 << (s - 1));
    return sum >> s;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pinhole_ground_plane_projection.sv
// Top level of the ground-plane projection block: box in, floor position out.
// Each box passes through the two CORDIC pipelines and the three bit-per-stage dividers
// for the tangent, the forward distance and the lateral distance. One box is accepted
// every cycle while the output buffer's second entry is empty; a two-entry output buffer
// keeps s_axis_tready registered and lets the pipeline run while a result waits to be taken.
// Rejected boxes come out with kept low and zero positions.
`default_nettype none

module pinhole_ground_plane_projection import pgp_pkg::*; #(
  parameter int PIXEL_BITS      = PIXEL_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // box_left[11:0], box_top[23:12], box_width[35:24], box_height[47:36], score_in[63:48]
  input  wire logic [63:0]         s_axis_tdata,
  input  wire logic                s_axis_tlast,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // floor_x[31:0], floor_y[63:32], score_out[79:64]
  output logic [79:0]              m_axis_tdata,
  // kept[0]
  output logic                     m_axis_tuser,
  output logic                     m_axis_tlast,
  input  wire logic                cfg_we_i,
  input  wire logic [REG_IDXW-1:0] cfg_addr_i,
  input  wire logic [REG_W-1:0]    cfg_wdata_i
);

  localparam int XW   = (PIXEL_BITS > BOX_FW) ? PIXEL_BITS : BOX_FW;
  localparam int SUMW = PIXEL_BITS + 5;
  localparam int DW   = ((SUMW > 16) ? SUMW : 16) + 1;
  localparam int VW   = DW + 18;
  localparam int AW   = ANGLE_FRAC_BITS + 4;
  localparam int RW   = 33;
  localparam int TNW  = 48;
  localparam int FNW  = 32;
  localparam int LNW  = 32 + DW;
  localparam int SHL  = (ANGLE_FRAC_BITS >= 13) ? ANGLE_FRAC_BITS - 13 : 0;
  localparam int SHR  = (ANGLE_FRAC_BITS < 13) ? 13 - ANGLE_FRAC_BITS : 0;
  localparam int MPW  = AW + 16;

  localparam logic signed [AW-1:0] HALF_PI_A = $signed(AW'(angle_const(HALF_PI_Q30,
                                                                        ANGLE_FRAC_BITS)));
  localparam logic signed [AW-1:0] PI_A      = $signed(AW'(angle_const(PI_Q30,
                                                                        ANGLE_FRAC_BITS)));
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic                 ok;
    logic signed [DW-1:0] dx;
    logic [SCORE_W-1:0]   score;
    logic                 fe;
  } item_t;

  typedef struct packed {
    item_t it;
    logic  yneg;
    logic  xle0;
  } tan_side_t;

  typedef struct packed {
    item_t it;
    logic  neg;
  } fwd_side_t;

  typedef struct packed {
    item_t       it;
    logic [31:0] fwd;
    logic        dxneg;
  } lat_side_t;

  typedef struct packed {
    logic               kept;
    logic [31:0]        floor_x;
    logic [31:0]        floor_y;
    logic [SCORE_W-1:0] score;
    logic               fe;
  } res_t;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    if (v > 33'(S32_MAX)) begin
      return S32_MAX;
    end else if (v < 33'(S32_MIN)) begin
      return S32_MIN;
    end
    return v[31:0];
  endfunction

  // Configuration registers.
  logic [15:0] centre_x_q, centre_y_q, focal_x_q, focal_y_q;
  logic signed [15:0] mount_x_q, mount_y_q, mount_height_q, mount_pitch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_x_q     <= RST_CENTRE_X;
      centre_y_q     <= RST_CENTRE_Y;
      focal_x_q      <= RST_FOCAL_X;
      focal_y_q      <= RST_FOCAL_Y;
      mount_x_q      <= RST_MOUNT_X;
      mount_y_q      <= RST_MOUNT_Y;
      mount_height_q <= RST_MOUNT_HEIGHT;
      mount_pitch_q  <= RST_MOUNT_PITCH;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_CENTRE_X:     centre_x_q     <= cfg_wdata_i;
        REG_CENTRE_Y:     centre_y_q     <= cfg_wdata_i;
        REG_FOCAL_X:      focal_x_q      <= cfg_wdata_i;
        REG_FOCAL_Y:      focal_y_q      <= cfg_wdata_i;
        REG_MOUNT_X:      mount_x_q      <= cfg_wdata_i;
        REG_MOUNT_Y:      mount_y_q      <= cfg_wdata_i;
        REG_MOUNT_HEIGHT: mount_height_q <= cfg_wdata_i;
        REG_MOUNT_PITCH:  mount_pitch_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [15:0] fx_nz, fy_nz;
  assign fx_nz = (focal_x_q == '0) ? 16'd1 : focal_x_q;
  assign fy_nz = (focal_y_q == '0) ? 16'd1 : focal_y_q;

  // Output buffer and pipeline enable.
  logic res_v_q, res_v_d, skid_v_q, skid_v_d;
  res_t res_q, res_d, skid_q, skid_d, res_new;
  logic en, take, lat_v;

  assign en            = !skid_v_q;
  assign take          = res_v_q && m_axis_tready;
  assign s_axis_tready = en;

  // Stage 1: box centre offsets.
  logic [XW-1:0] left_x, top_x, wid_x, hgt_x;
  logic [PIXEL_BITS-1:0] left_p, top_p, wid_p, hgt_p;
  logic [SUMW-1:0] sum_x, sum_y;
  item_t it1_d, it1_q;
  logic signed [DW-1:0] dy1_d, dy1_q;
  logic v1_q;

  assign left_x = XW'(s_axis_tdata[11:0]);
  assign top_x  = XW'(s_axis_tdata[23:12]);
  assign wid_x  = XW'(s_axis_tdata[35:24]);
  assign hgt_x  = XW'(s_axis_tdata[47:36]);
  assign left_p = left_x[PIXEL_BITS-1:0];
  assign top_p  = top_x[PIXEL_BITS-1:0];
  assign wid_p  = wid_x[PIXEL_BITS-1:0];
  assign hgt_p  = hgt_x[PIXEL_BITS-1:0];
  assign sum_x  = (SUMW'(left_p) << 4) + (SUMW'(wid_p) << 3);
  assign sum_y  = (SUMW'(top_p) << 4) + (SUMW'(hgt_p) << 3);

  always_comb begin
    it1_d.ok    = (wid_p != '0) && (hgt_p != '0);
    it1_d.dx    = $signed(DW'(sum_x)) - $signed(DW'(centre_x_q));
    it1_d.score = s_axis_tdata[63:48];
    it1_d.fe    = s_axis_tlast;
    dy1_d       = $signed(DW'(sum_y)) - $signed(DW'(centre_y_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      it1_q <= it1_d;
      dy1_q <= dy1_d;
    end
  end

  // Ray pitch angle.
  logic signed [VW-1:0] vx_in, vy_in, vx_out, vy_out;
  logic signed [AW-1:0] ray_z;
  item_t it_v;
  logic v_v;

  assign vx_in = $signed(VW'({fy_nz, 16'h0000}));
  assign vy_in = VW'(dy1_q) <<< 16;

  pgp_cordic #(
    .W(VW), .AW(AW), .AFB(ANGLE_FRAC_BITS), .STAGES(CORDIC_STAGES),
    .VECTORING(1'b1), .SIDE_W($bits(item_t))
  ) u_ray (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1_q),
    .x_i(vx_in), .y_i(vy_in), .z_i('0), .side_i(it1_q),
    .valid_o(v_v), .x_o(vx_out), .y_o(vy_out), .z_o(ray_z), .side_o(it_v)
  );

  // Stage 2: camera pitch and reduction into a half turn.
  logic signed [MPW-1:0] mp_wide, mp_sh;
  logic signed [AW-1:0] a2_d, a2_q;
  item_t it2_q;
  logic v2_q;

  assign mp_wide = MPW'(mount_pitch_q);
  assign mp_sh   = (ANGLE_FRAC_BITS >= 13) ? (mp_wide <<< SHL) : (mp_wide >>> SHR);

  always_comb begin
    a2_d = AW'(mp_sh) + ray_z;
    for (int i = 0; i < 4; i++) begin
      if (a2_d > HALF_PI_A) begin
        a2_d = a2_d - PI_A;
      end else if (a2_d < -HALF_PI_A) begin
        a2_d = a2_d + PI_A;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a2_q  <= a2_d;
      it2_q <= it_v;
    end
  end

  // Sine and cosine of the summed angle.
  logic signed [RW-1:0] rx, ry, rx_in;
  logic signed [AW-1:0] rz;
  item_t it_r;
  logic v_r;

  assign rx_in = RW'(1) <<< 30;

  pgp_cordic #(
    .W(RW), .AW(AW), .AFB(ANGLE_FRAC_BITS), .STAGES(CORDIC_STAGES),
    .VECTORING(1'b0), .SIDE_W($bits(item_t))
  ) u_rot (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v2_q),
    .x_i(rx_in), .y_i('0), .z_i(a2_q), .side_i(it2_q),
    .valid_o(v_r), .x_o(rx), .y_o(ry), .z_o(rz), .side_o(it_r)
  );

  // Tangent in Q16.16.
  logic [RW-1:0] ry_abs;
  tan_side_t ts_in, ts_out;
  logic [TNW-1:0] tq;
  logic v_t;

  assign ry_abs = ry[RW-1] ? RW'(-ry) : RW'(ry);

  always_comb begin
    ts_in.it   = it_r;
    ts_in.yneg = ry[RW-1];
    ts_in.xle0 = (rx <= 0);
  end

  pgp_div #(.NW(TNW), .DENW(32), .SIDE_W($bits(tan_side_t))) u_tan (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v_r),
    .num_i({ry_abs[31:0], 16'h0000}), .den_i(rx[31:0]), .side_i(ts_in),
    .valid_o(v_t), .quot_o(tq), .side_o(ts_out)
  );

  // Stage 3: saturate the tangent and reject flat rays.
  logic signed [31:0] t3_d, t3_q;
  item_t it3_d, it3_q;
  logic v3_q;

  always_comb begin
    if (ts_out.xle0) begin
      t3_d = ts_out.yneg ? S32_MIN : S32_MAX;
    end else if (!ts_out.yneg) begin
      t3_d = (tq > TNW'(32'h7FFF_FFFF)) ? S32_MAX : $signed(tq[31:0]);
    end else begin
      t3_d = (tq > TNW'(32'h8000_0000)) ? S32_MIN : $signed(-tq[31:0]);
    end
    it3_d    = ts_out.it;
    it3_d.ok = ts_out.it.ok && !((t3_d < TAN_MIN_Q) && (t3_d > -TAN_MIN_Q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v_t;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t3_q  <= t3_d;
      it3_q <= it3_d;
    end
  end

  // Forward distance.
  logic [15:0] h_abs;
  logic [31:0] t_abs, fq;
  fwd_side_t fs_in, fs_out;
  logic v_f;

  assign h_abs = mount_height_q[15] ? 16'(-mount_height_q) : mount_height_q;
  assign t_abs = t3_q[31] ? 32'(-t3_q) : t3_q;

  always_comb begin
    fs_in.it  = it3_q;
    fs_in.neg = mount_height_q[15] ^ t3_q[31];
  end

  pgp_div #(.NW(FNW), .DENW(32), .SIDE_W($bits(fwd_side_t))) u_fwd (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v3_q),
    .num_i({h_abs, 16'h0000}), .den_i(t_abs), .side_i(fs_in),
    .valid_o(v_f), .quot_o(fq), .side_o(fs_out)
  );

  // Stage 4: forward check and lateral product.
  logic [DW-1:0] dx_abs;
  lat_side_t ls_d, ls_q, ls_out;
  logic [LNW-1:0] prod_d, prod_q, lq;
  logic v4_q;

  assign dx_abs = fs_out.it.dx[DW-1] ? DW'(-fs_out.it.dx) : DW'(fs_out.it.dx);
  assign prod_d = LNW'(fq) * LNW'(dx_abs);

  always_comb begin
    ls_d       = '0;
    ls_d.it    = fs_out.it;
    ls_d.it.ok = fs_out.it.ok && !fs_out.neg && (fq != '0);
    ls_d.fwd   = fq;
    ls_d.dxneg = fs_out.it.dx[DW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v_f;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ls_q   <= ls_d;
      prod_q <= prod_d;
    end
  end

  // Lateral distance.
  pgp_div #(.NW(LNW), .DENW(16), .SIDE_W($bits(lat_side_t))) u_lat (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v4_q),
    .num_i(prod_q), .den_i(fx_nz), .side_i(ls_q),
    .valid_o(lat_v), .quot_o(lq), .side_o(ls_out)
  );

  // Final offsets and saturation.
  logic signed [31:0] lat_s;

  always_comb begin
    if (ls_out.dxneg) begin
      lat_s = (lq > LNW'(32'h8000_0000)) ? S32_MIN : $signed(-lq[31:0]);
    end else begin
      lat_s = (lq > LNW'(32'h7FFF_FFFF)) ? S32_MAX : $signed(lq[31:0]);
    end
    res_new.kept  = ls_out.it.ok;
    res_new.score = ls_out.it.score;
    res_new.fe    = ls_out.it.fe;
    if (ls_out.it.ok) begin
      res_new.floor_x = sat32(33'(mount_x_q) + $signed({1'b0, ls_out.fwd}));
      res_new.floor_y = sat32(33'(mount_y_q) + 33'(lat_s));
    end else begin
      res_new.floor_x = '0;
      res_new.floor_y = '0;
    end
  end

  always_comb begin
    res_v_d  = res_v_q;
    skid_v_d = skid_v_q;
    res_d    = res_q;
    skid_d   = skid_q;
    if (skid_v_q) begin
      if (take) begin
        res_d    = skid_q;
        skid_v_d = 1'b0;
      end
    end else if (lat_v) begin
      if (!res_v_q || take) begin
        res_v_d = 1'b1;
        res_d   = res_new;
      end else begin
        skid_v_d = 1'b1;
        skid_d   = res_new;
      end
    end else if (take) begin
      res_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      res_v_q  <= res_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = res_v_q;
  assign m_axis_tdata  = {res_q.score, res_q.floor_y, res_q.floor_x};
  assign m_axis_tuser  = res_q.kept;
  assign m_axis_tlast  = res_q.fe;

  a_skid_implies_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> res_v_q)
    else $error("skid entry held without an output entry");

  a_reject_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_v_q && !res_q.kept) |-> (res_q.floor_x == '0 && res_q.floor_y == '0))
    else $error("rejected box carries a nonzero position");

  a_kept_ahead : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_v_q && res_q.kept) |-> ($signed(res_q.floor_x) > 32'(mount_x_q)))
    else $error("kept box lies behind the camera mount");

endmodule

`default_nettype wire

FILE: hw/rtl/pgp_cordic.sv
// Pipelined CORDIC, one micro-rotation per register stage, vectoring or rotation mode.
`default_nettype none

module pgp_cordic import pgp_pkg::*; #(
  parameter int W         = 33,
  parameter int AW        = 17,
  parameter int AFB       = ANGLE_FRAC_BITS_DEF,
  parameter int STAGES    = CORDIC_STAGES_DEF,
  parameter bit VECTORING = 1'b0,
  parameter int SIDE_W    = 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic signed [W-1:0]  x_i,
  input  wire logic signed [W-1:0]  y_i,
  input  wire logic signed [AW-1:0] z_i,
  input  wire logic [SIDE_W-1:0]    side_i,
  output logic                      valid_o,
  output logic signed [W-1:0]       x_o,
  output logic signed [W-1:0]       y_o,
  output logic signed [AW-1:0]      z_o,
  output logic [SIDE_W-1:0]         side_o
);

  localparam int NS = (STAGES < CORDIC_MAX_STAGES) ? STAGES : CORDIC_MAX_STAGES;

  logic signed [W-1:0]  x_q [NS];
  logic signed [W-1:0]  y_q [NS];
  logic signed [AW-1:0] z_q [NS];
  logic [SIDE_W-1:0]    side_q [NS];
  logic [NS-1:0]        v_q;
  logic signed [W-1:0]  x_d [NS];
  logic signed [W-1:0]  y_d [NS];
  logic signed [AW-1:0] z_d [NS];
  logic [SIDE_W-1:0]    side_d [NS];

  always_comb begin
    logic signed [W-1:0]  px, py, xs, ys;
    logic signed [AW-1:0] pz, t;
    logic                 dir;
    for (int k = 0; k < NS; k++) begin
      px = (k == 0) ? x_i : x_q[(k == 0) ? 0 : k - 1];
      py = (k == 0) ? y_i : y_q[(k == 0) ? 0 : k - 1];
      pz = (k == 0) ? z_i : z_q[(k == 0) ? 0 : k - 1];
      side_d[k] = (k == 0) ? side_i : side_q[(k == 0) ? 0 : k - 1];
      xs  = px >>> k;
      ys  = py >>> k;
      t   = $signed(AW'(angle_const(ATAN_Q30[k], AFB)));
      dir = VECTORING ? !(py > 0) : (pz >= 0);
      if (dir) begin
        x_d[k] = px - ys;
        y_d[k] = py + xs;
        z_d[k] = pz - t;
      end else begin
        x_d[k] = px + ys;
        y_d[k] = py - xs;
        z_d[k] = pz + t;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      for (int k = 0; k < NS; k++) begin
        v_q[k] <= (k == 0) ? valid_i : v_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      side_q <= side_d;
    end
  end

  assign valid_o = v_q[NS-1];
  assign x_o     = x_q[NS-1];
  assign y_o     = y_q[NS-1];
  assign z_o     = z_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

`default_nettype wire

FILE: hw/rtl/pgp_div.sv
// Pipelined unsigned restoring divider, one quotient bit per register stage.
`default_nettype none

module pgp_div import pgp_pkg::*; #(
  parameter int NW     = 32,
  parameter int DENW   = 32,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [NW-1:0]     num_i,
  input  wire logic [DENW-1:0]   den_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   valid_o,
  output logic [NW-1:0]          quot_o,
  output logic [SIDE_W-1:0]      side_o
);

  logic [NW-1:0]     num_q [NW];
  logic [DENW-1:0]   rem_q [NW];
  logic [DENW-1:0]   den_q [NW];
  logic [SIDE_W-1:0] side_q [NW];
  logic [NW-1:0]     v_q;
  logic [NW-1:0]     num_d [NW];
  logic [DENW-1:0]   rem_d [NW];
  logic [DENW-1:0]   den_d [NW];
  logic [SIDE_W-1:0] side_d [NW];

  always_comb begin
    logic [NW-1:0]   pnum;
    logic [DENW-1:0] prem;
    logic [DENW:0]   trial;
    logic            ge;
    for (int k = 0; k < NW; k++) begin
      pnum      = (k == 0) ? num_i  : num_q[(k == 0) ? 0 : k - 1];
      prem      = (k == 0) ? '0     : rem_q[(k == 0) ? 0 : k - 1];
      den_d[k]  = (k == 0) ? den_i  : den_q[(k == 0) ? 0 : k - 1];
      side_d[k] = (k == 0) ? side_i : side_q[(k == 0) ? 0 : k - 1];
      trial     = {prem, pnum[NW-1-k]};
      ge        = trial >= {1'b0, den_d[k]};
      rem_d[k]  = ge ? DENW'(trial - {1'b0, den_d[k]}) : trial[DENW-1:0];
      num_d[k]  = pnum;
      num_d[k][NW-1-k] = ge;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      for (int k = 0; k < NW; k++) begin
        v_q[k] <= (k == 0) ? valid_i : v_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q  <= num_d;
      rem_q  <= rem_d;
      den_q  <= den_d;
      side_q <= side_d;
    end
  end

  assign valid_o = v_q[NW-1];
  assign quot_o  = num_q[NW-1];
  assign side_o  = side_q[NW-1];

endmodule

`default_nettype wire
